// File: design/nec_ir_frame_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// NEC IR frame decoder assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_TOP_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define NIR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nir assertion failed");
// next-cycle implication
`define NIR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nir assertion failed");
`else
`define NIR_ASSERT_IMP(lbl, ante, cons)
`define NIR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: design/nir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Field widths, status codes, phase encoding and interval windows.
// ----------------------------------------------------------------------------
package nir_pkg;

	localparam int unsigned IntervalW = 16;
	localparam int unsigned StatusW   = 2;
	localparam int unsigned CodeW     = 8;
	localparam int unsigned BitCntW   = 5;

	typedef logic [IntervalW-1:0] interval_t;
	typedef logic [StatusW-1:0]   status_t;
	typedef logic [CodeW-1:0]     code_t;
	typedef logic [BitCntW-1:0]   bit_cnt_t;

	localparam status_t ST_NONE  = 2'd0;
	localparam status_t ST_DONE  = 2'd1;
	localparam status_t ST_ABORT = 2'd2;

	localparam logic CMD_EDGE    = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_LEADER   = 5'b00010,
		PH_SPACE    = 5'b00100,
		PH_PULSE    = 5'b01000,
		PH_BITSPACE = 5'b10000
	} phase_t;

	// windows, inclusive, in 2 us ticks
	localparam interval_t LEADER_LO = 16'd4250;
	localparam interval_t LEADER_HI = 16'd4750;
	localparam interval_t SPACE_LO  = 16'd2000;
	localparam interval_t SPACE_HI  = 16'd2500;
	localparam interval_t PULSE_LO  = 16'd200;
	localparam interval_t PULSE_HI  = 16'd350;
	localparam interval_t BSPACE_LO = 16'd200;
	localparam interval_t BSPACE_HI = 16'd900;
	localparam interval_t ONE_MIN   = 16'd500;

	// first kept cell and last cell
	localparam bit_cnt_t FIRST_KEPT = 5'd24;
	localparam bit_cnt_t LAST_CELL  = 5'd31;

endpackage

// File: design/nir_evt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR event channel
// Valid/ready channel carrying one edge or timeout event per beat.
// ----------------------------------------------------------------------------
interface nir_evt_if
	import nir_pkg::*;
();
	logic      valid;
	logic      ready;
	logic      cmd;
	interval_t interval;

	modport source (output valid, output cmd, output interval, input ready);
	modport sink   (input valid, input cmd, input interval, output ready);
endinterface

// File: design/nir_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR result channel
// Valid/ready channel carrying one status/code result per beat.
// ----------------------------------------------------------------------------
interface nir_res_if
	import nir_pkg::*;
();
	logic    valid;
	logic    ready;
	status_t status;
	code_t   code;

	modport source (output valid, output status, output code, input ready);
	modport sink   (input valid, input status, input code, output ready);
endinterface

// File: design/nec_ir_frame_decoder_top.sv
// A result beat is presented in the cycle after its event beat is taken.
// Throughput: one event per cycle; the output register stalls intake only
// while a held result is not taken.
// Reset: arst_n clears phase, bit count and the output valid; the decoder
// starts idle.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Checks leader, space and 32 bit cells of an NEC frame from edge intervals
// and reports the last eight bits or an abort, one result per event.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_decoder_top_defines.svh"

module nec_ir_frame_decoder_top
	import nir_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	nir_evt_if.sink       evt,
	nir_res_if.source     res
);

	phase_t   phase_q, phase_nxt;
	bit_cnt_t bit_cnt_q, bit_cnt_nxt;
	code_t    code_shift_q, code_shift_nxt;

	logic     res_vld_q;
	status_t  res_status_q;
	code_t    res_code_q;

	status_t  status_nxt;
	code_t    code_nxt;
	logic     evt_acc;
	logic     is_one;

	assign evt.ready = !res_vld_q || res.ready;
	assign evt_acc   = evt.valid && evt.ready;
	assign is_one    = evt.interval > ONE_MIN;

	always_comb begin
		phase_nxt      = phase_q;
		bit_cnt_nxt    = bit_cnt_q;
		code_shift_nxt = code_shift_q;
		status_nxt     = ST_NONE;
		code_nxt       = '0;
		case (phase_q)
			PH_LEADER: begin
				if (evt.cmd == CMD_TIMEOUT) status_nxt = ST_ABORT;
				else if (evt.interval >= LEADER_LO && evt.interval <= LEADER_HI)
					phase_nxt = PH_SPACE;
				else status_nxt = ST_ABORT;
			end
			PH_SPACE: begin
				if (evt.cmd == CMD_TIMEOUT) status_nxt = ST_ABORT;
				else if (evt.interval >= SPACE_LO && evt.interval <= SPACE_HI)
					phase_nxt = PH_PULSE;
				else status_nxt = ST_ABORT;
			end
			PH_PULSE: begin
				if (evt.cmd == CMD_TIMEOUT) status_nxt = ST_ABORT;
				else if (evt.interval >= PULSE_LO && evt.interval <= PULSE_HI)
					phase_nxt = PH_BITSPACE;
				else status_nxt = ST_ABORT;
			end
			PH_BITSPACE: begin
				if (evt.cmd == CMD_TIMEOUT) status_nxt = ST_ABORT;
				else if (evt.interval < BSPACE_LO || evt.interval > BSPACE_HI)
					status_nxt = ST_ABORT;
				else begin
					// cells 24..31 land MSB first
					if (bit_cnt_q >= FIRST_KEPT)
						code_shift_nxt[~bit_cnt_q[2:0]] = is_one;
					if (bit_cnt_q == LAST_CELL) begin
						status_nxt  = ST_DONE;
						code_nxt    = code_shift_nxt;
						phase_nxt   = PH_IDLE;
						bit_cnt_nxt = '0;
					end else begin
						bit_cnt_nxt = bit_cnt_q + 5'd1;
						phase_nxt   = PH_PULSE;
					end
				end
			end
			default: begin
				phase_nxt = PH_IDLE;
				if (evt.cmd == CMD_EDGE) begin
					phase_nxt   = PH_LEADER;
					bit_cnt_nxt = '0;
				end
			end
		endcase
		if (status_nxt == ST_ABORT) begin
			phase_nxt   = PH_IDLE;
			bit_cnt_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
		end else if (evt_acc) begin
			phase_q   <= phase_nxt;
			bit_cnt_q <= bit_cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			code_shift_q <= code_shift_nxt;
			res_status_q <= status_nxt;
			res_code_q   <= code_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (evt_acc) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	assign res.valid  = res_vld_q;
	assign res.status = res_status_q;
	assign res.code   = res_code_q;

	`NIR_ASSERT_NXT(a_evt_gives_res, evt_acc, res_vld_q)
	`NIR_ASSERT_NXT(a_idle_no_status, evt_acc && phase_q == PH_IDLE,
		res_status_q == ST_NONE)
	`NIR_ASSERT_NXT(a_timeout_aborts,
		evt_acc && evt.cmd == CMD_TIMEOUT && phase_q != PH_IDLE,
		phase_q == PH_IDLE && res_status_q == ST_ABORT)
	`NIR_ASSERT_IMP(a_status_legal, res_vld_q,
		res_status_q == ST_NONE || res_status_q == ST_DONE || res_status_q == ST_ABORT)
	`NIR_ASSERT_NXT(a_done_from_bitspace,
		evt_acc && status_nxt == ST_DONE,
		phase_q == PH_IDLE && bit_cnt_q == '0)

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Drives edge and timeout events into the decoder and predicts each status and
// code beat in a small scoreboard. The first events hit the window edges and
// the abort cases. Random frames follow: most are well formed with random bit
// values, some are cut by a timeout or a bad interval, and there are idle
// timeouts between frames. The sender and receiver throttle in four settings.
// ----------------------------------------------------------------------------
module tb_top;
	import nir_pkg::*;

	typedef struct packed {
		status_t status;
		code_t   code;
	} ir_result_t;

	typedef struct packed {
		logic      cmd;
		interval_t interval;
	} ir_event_t;

	class ir_frame_scoreboard;
		phase_t      ph;
		int unsigned cells;
		code_t       kept_bits;
		ir_result_t  pending_results[$];
		int unsigned errors;
		int unsigned events_seen;
		int unsigned frames_done;
		int unsigned frames_aborted;

		function new();
			ph = PH_IDLE;
			cells = 0;
			kept_bits = '0;
			errors = 0;
			events_seen = 0;
			frames_done = 0;
			frames_aborted = 0;
		endfunction

		function automatic bit in_win(interval_t iv, interval_t lo, interval_t hi);
			return iv >= lo && iv <= hi;
		endfunction

		function void note_event(logic cmd, interval_t iv);
			ir_result_t r;
			r.status = ST_NONE;
			r.code = '0;
			events_seen++;
			if (ph == PH_IDLE) begin
				if (cmd == CMD_EDGE) begin
					ph = PH_LEADER;
					cells = 0;
				end
			end else if (cmd == CMD_TIMEOUT) begin
				r.status = ST_ABORT;
			end else begin
				case (ph)
					PH_LEADER: begin
						if (in_win(iv, LEADER_LO, LEADER_HI)) ph = PH_SPACE;
						else r.status = ST_ABORT;
					end
					PH_SPACE: begin
						if (in_win(iv, SPACE_LO, SPACE_HI)) ph = PH_PULSE;
						else r.status = ST_ABORT;
					end
					PH_PULSE: begin
						if (in_win(iv, PULSE_LO, PULSE_HI)) ph = PH_BITSPACE;
						else r.status = ST_ABORT;
					end
					default: begin
						if (!in_win(iv, BSPACE_LO, BSPACE_HI)) begin
							r.status = ST_ABORT;
						end else begin
							if (cells >= FIRST_KEPT)
								kept_bits[int'(LAST_CELL) - int'(cells)] = (iv > ONE_MIN);
							cells++;
							if (cells > LAST_CELL) begin
								r.status = ST_DONE;
								r.code = kept_bits;
								ph = PH_IDLE;
								cells = 0;
							end else begin
								ph = PH_PULSE;
							end
						end
					end
				endcase
			end
			if (r.status == ST_ABORT) begin
				ph = PH_IDLE;
				cells = 0;
			end
			if (r.status == ST_DONE) frames_done++;
			if (r.status == ST_ABORT) frames_aborted++;
			pending_results.push_back(r);
		endfunction

		function void check_result(status_t status, code_t code);
			ir_result_t exp_r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat status %0d code 0x%02h",
					$time, status, code);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (status !== exp_r.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, exp_r.status, status);
				errors++;
			end
			if (code !== exp_r.code) begin
				$display("%0t: code mismatch: expected 0x%02h, actual 0x%02h",
					$time, exp_r.code, code);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	ir_frame_scoreboard sb;
	ir_event_t directed_q[$];

	nir_evt_if evt();
	nir_res_if res();

	nec_ir_frame_decoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.res    (res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_result(res.status, res.code);
		res.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_event(logic cmd, interval_t iv);
		while ($urandom_range(99) < send_idle_pct) begin
			evt.valid <= 1'b0;
			@(posedge clk);
		end
		evt.valid <= 1'b1;
		evt.cmd <= cmd;
		evt.interval <= iv;
		@(posedge clk);
		while (!evt.ready) @(posedge clk);
		sb.note_event(cmd, iv);
	endtask

	task automatic drain();
		evt.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic interval_t pick_in(interval_t lo, interval_t hi);
		case ($urandom_range(9))
			0: return lo;
			1: return hi;
			default: return interval_t'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic interval_t pick_out(interval_t lo, interval_t hi);
		case ($urandom_range(3))
			0: return lo - 1'b1;
			1: return hi + 1'b1;
			2: return interval_t'($urandom_range(lo - 1, 0));
			default: return interval_t'($urandom_range(16'hFFFF, hi + 1));
		endcase
	endfunction

	// one frame; about a third are cut short by a timeout or a bad interval
	task automatic send_frame();
		int        bad_at;
		interval_t lo;
		interval_t hi;
		bit        is_one;
		bad_at = ($urandom_range(99) < 35) ? int'($urandom_range(66)) : -1;
		if (bad_at == 0) send_event(CMD_TIMEOUT, interval_t'($urandom));
		send_event(CMD_EDGE, interval_t'($urandom));
		for (int i = 1; i <= 66; i++) begin
			if ($urandom_range(199) == 0) drain();
			if (i == 1) begin
				lo = LEADER_LO;
				hi = LEADER_HI;
			end else if (i == 2) begin
				lo = SPACE_LO;
				hi = SPACE_HI;
			end else if (i % 2 == 1) begin
				lo = PULSE_LO;
				hi = PULSE_HI;
			end else begin
				lo = BSPACE_LO;
				hi = BSPACE_HI;
			end
			if (i == bad_at) begin
				if ($urandom_range(3) == 0) send_event(CMD_TIMEOUT, interval_t'($urandom));
				else send_event(CMD_EDGE, pick_out(lo, hi));
				return;
			end
			if (i > 2 && i % 2 == 0) begin
				is_one = $urandom_range(1);
				if (is_one) lo = ONE_MIN + 1'b1;
				else hi = ONE_MIN;
			end
			send_event(CMD_EDGE, pick_in(lo, hi));
		end
		repeat ($urandom_range(2)) send_event(CMD_TIMEOUT, interval_t'($urandom));
	endtask

	initial begin
		int unsigned phase_start;
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		evt.valid = 1'b0;
		evt.cmd = CMD_EDGE;
		evt.interval = '0;
		res.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_q = '{
			'{CMD_TIMEOUT, 16'd0},
			'{CMD_EDGE, 16'hFFFF}, '{CMD_EDGE, 16'd4249},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd4751},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd4250}, '{CMD_EDGE, 16'd1999},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd4750}, '{CMD_EDGE, 16'd2501},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd4500}, '{CMD_EDGE, 16'd2000},
			'{CMD_EDGE, 16'd199},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd4500}, '{CMD_EDGE, 16'd2500},
			'{CMD_EDGE, 16'd351},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd4500}, '{CMD_EDGE, 16'd2250},
			'{CMD_EDGE, 16'd200},  '{CMD_EDGE, 16'd199},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd4500}, '{CMD_EDGE, 16'd2250},
			'{CMD_EDGE, 16'd350},  '{CMD_EDGE, 16'd901},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd4500}, '{CMD_TIMEOUT, 16'hFFFF},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'd0},
			'{CMD_EDGE, 16'd0},    '{CMD_EDGE, 16'hFFFF}
		};
		foreach (directed_q[i])
			send_event(directed_q[i].cmd, directed_q[i].interval);
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			phase_start = sb.events_seen;
			while (sb.events_seen - phase_start < 225) send_frame();
			drain();
		end
		recv_stall_pct = 0;

		repeat (5) @(posedge clk);
		$display("Covered %0d events: %0d frames decoded, %0d frames aborted,",
			sb.events_seen, sb.frames_done, sb.frames_aborted);
		$display("window edges, idle and mid-frame timeouts, four throttle settings.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d results missing", sb.errors, sb.pending());
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout at %0t", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
